FILE: design/dlpm_pkg.sv
package dlpm_pkg;

  // Event kinds carried on the input tuser field
  typedef enum logic [3:0] {
    KIND_CLEAR       = 4'd0,
    KIND_USB_REQUEST = 4'd1,
    KIND_RF_START    = 4'd2,
    KIND_RF_DONE     = 4'd3,
    KIND_RX_RESTORED = 4'd4,
    KIND_ACK         = 4'd5,
    KIND_SWD_RESP    = 4'd6,
    KIND_USB_IN_DONE = 4'd7,
    KIND_DEPTH       = 4'd8,
    KIND_PAGE_READ   = 4'd9
  } kind_t;

  // Work handed from the front to the back
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_USB,
    OP_RF,
    OP_LATENCY,
    OP_DEPTH,
    OP_PAGE,
    OP_REJECT
  } op_t;

  // Back part sequencing
  typedef enum logic {
    ST_RUN,
    ST_PAGE
  } back_state_t;

  // value: count, frame bytes, latency sample, depth or elapsed time
  // sel:   command class, latency slot or page number
  // flag:  class valid or retransmission
  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic [1:0]  sel;
    logic        flag;
    logic [2:0]  bin;
    logic        bin_valid;
  } cmd_t;

  // Command codes
  localparam logic [7:0] CMD_TRANSFER       = 8'h05;
  localparam logic [7:0] CMD_TRANSFER_BLOCK = 8'h06;
  localparam logic [7:0] CMD_QUEUE          = 8'h7E;
  localparam logic [7:0] CMD_EXECUTE        = 8'h7F;

  // Command classes
  localparam logic [1:0] CLASS_TRANSFER = 2'd0;
  localparam logic [1:0] CLASS_BLOCK    = 2'd1;
  localparam logic [1:0] CLASS_QUEUE    = 2'd2;
  localparam logic [1:0] CLASS_EXECUTE  = 2'd3;

  // Latency slots
  localparam logic [1:0] LAT_ACK = 2'd0;
  localparam logic [1:0] LAT_SWD = 2'd1;
  localparam logic [1:0] LAT_USB = 2'd2;
  localparam logic [1:0] LAT_RX  = 2'd3;

  // Page layout
  localparam logic [31:0] STATS_VERSION   = 32'd2;
  localparam logic [7:0]  MAX_PAGE        = 8'd2;
  localparam logic [7:0]  PAGE_BYTES_MIN  = 8'd60;
  localparam logic [5:0]  PAGE_BYTES      = 6'd60;
  localparam logic [3:0]  LAST_WORD_INDEX = 4'd14;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

endpackage

FILE: design/debug_link_perf_monitor_unit.sv
// Performance monitor for a wireless debug probe. Each input word is one
// timestamped event (kind in tuser) and is taken back to back as long as
// the command queue between the front and back parts has room. The front
// part classifies USB requests, measures latencies as timestamp differences
// and keeps the session and reference times; the back part applies one
// queued event a cycle to the counters while no page read holds it. A page
// read (kind 9) streams fifteen 32-bit words, one a cycle while the output
// is ready, or a single reject word when the page is above 2 or the offered
// room is below 60 bytes; while a page streams the back part applies no
// later events, so the queue fills and tready falls after QUEUE_DEPTH further
// words. Write cycles_per_microsecond only while no event is in flight.
module debug_link_perf_monitor_unit import dlpm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  // Events
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // timestamp[31:0] command_byte[39:32] request_length[47:40]
  // count_low_byte[55:48] count_high_byte[63:56] frame_bytes[71:64]
  // is_retransmit[72] ring_depth[80:73] page_number[88:81]
  // buffer_capacity[96:89], zero fill above
  input  logic [103:0] s_axis_tdata,
  // kind[3:0]
  input  logic [3:0]   s_axis_tuser,
  // Page words
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // data_word[31:0] word_index[35:32] returned_length[41:36], zero fill above
  output logic [47:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  logic [15:0] cycles_per_microsecond;
  logic        accept;
  logic        push;
  cmd_t        push_cmd;
  logic        full;
  logic        head_valid;
  cmd_t        head;
  logic        pop;
  logic [31:0] data_word;
  logic [3:0]  word_index;
  logic [5:0]  returned_length;

  // Hold the tick rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_microsecond <= 16'd64;
    end else if (cfg_we) begin
      cycles_per_microsecond <= cfg_wdata;
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  dlpm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .kind            (kind_t'(s_axis_tuser)),
    .timestamp       (s_axis_tdata[31:0]),
    .command_byte    (s_axis_tdata[39:32]),
    .request_length  (s_axis_tdata[47:40]),
    .count_low_byte  (s_axis_tdata[55:48]),
    .count_high_byte (s_axis_tdata[63:56]),
    .frame_bytes     (s_axis_tdata[71:64]),
    .is_retransmit   (s_axis_tdata[72]),
    .ring_depth      (s_axis_tdata[80:73]),
    .page_number     (s_axis_tdata[88:81]),
    .buffer_capacity (s_axis_tdata[96:89]),
    .push            (push),
    .cmd             (push_cmd)
  );

  dlpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  dlpm_back u_back (
    .clk                    (clk),
    .rst                    (rst),
    .cycles_per_microsecond (cycles_per_microsecond),
    .head_valid             (head_valid),
    .head                   (head),
    .pop                    (pop),
    .out_valid              (m_axis_tvalid),
    .out_ready              (m_axis_tready),
    .data_word              (data_word),
    .word_index             (word_index),
    .last_word              (m_axis_tlast),
    .returned_length        (returned_length)
  );

  assign m_axis_tdata = {6'd0, returned_length, word_index, data_word};

endmodule

FILE: design/dlpm_front.sv
module dlpm_front import dlpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  kind_t       kind,
  input  logic [31:0] timestamp,
  input  logic [7:0]  command_byte,
  input  logic [7:0]  request_length,
  input  logic [7:0]  count_low_byte,
  input  logic [7:0]  count_high_byte,
  input  logic [7:0]  frame_bytes,
  input  logic        is_retransmit,
  input  logic [7:0]  ring_depth,
  input  logic [7:0]  page_number,
  input  logic [7:0]  buffer_capacity,
  output logic        push,
  output cmd_t        cmd
);

  logic [31:0] session_base;
  logic [31:0] send_done_time;
  logic [31:0] ack_time;
  logic [31:0] response_time;

  logic [15:0] count;
  logic [1:0]  cls;
  logic        cls_valid;
  logic [2:0]  bin;

  // Classify a USB request and pick its transfer count
  always_comb begin
    count     = '0;
    cls       = CLASS_TRANSFER;
    cls_valid = 1'b0;
    if (command_byte == CMD_TRANSFER && request_length >= 8'd3) begin
      cls       = CLASS_TRANSFER;
      cls_valid = 1'b1;
      count     = {8'd0, count_low_byte};
    end else if (command_byte == CMD_TRANSFER_BLOCK && request_length >= 8'd5) begin
      cls       = CLASS_BLOCK;
      cls_valid = 1'b1;
      count     = {count_high_byte, count_low_byte};
    end else if (command_byte == CMD_QUEUE) begin
      cls       = CLASS_QUEUE;
      cls_valid = 1'b1;
    end else if (command_byte == CMD_EXECUTE) begin
      cls       = CLASS_EXECUTE;
      cls_valid = 1'b1;
    end
  end

  // Size histogram bin
  always_comb begin
    if (count == 16'd1)       bin = 3'd0;
    else if (count == 16'd2)  bin = 3'd1;
    else if (count <= 16'd4)  bin = 3'd2;
    else if (count <= 16'd8)  bin = 3'd3;
    else if (count <= 16'd12) bin = 3'd4;
    else                      bin = 3'd5;
  end

  // Build the queue word for the event
  always_comb begin
    push          = 1'b0;
    cmd.op        = OP_CLEAR;
    cmd.value     = '0;
    cmd.sel       = '0;
    cmd.flag      = 1'b0;
    cmd.bin       = '0;
    cmd.bin_valid = 1'b0;
    case (kind)
      KIND_CLEAR: begin
        push = accept;
      end
      KIND_USB_REQUEST: begin
        push          = accept;
        cmd.op        = OP_USB;
        cmd.value     = {16'd0, count};
        cmd.sel       = cls;
        cmd.flag      = cls_valid;
        cmd.bin       = bin;
        cmd.bin_valid = (count != 16'd0);
      end
      KIND_RF_START: begin
        push      = accept;
        cmd.op    = OP_RF;
        cmd.value = {24'd0, frame_bytes};
        cmd.flag  = is_retransmit;
      end
      KIND_RX_RESTORED: begin
        push      = accept;
        cmd.op    = OP_LATENCY;
        cmd.value = timestamp - send_done_time;
        cmd.sel   = LAT_RX;
      end
      KIND_ACK: begin
        push      = accept;
        cmd.op    = OP_LATENCY;
        cmd.value = timestamp - send_done_time;
        cmd.sel   = LAT_ACK;
      end
      KIND_SWD_RESP: begin
        push      = accept;
        cmd.op    = OP_LATENCY;
        cmd.value = timestamp - ack_time;
        cmd.sel   = LAT_SWD;
      end
      KIND_USB_IN_DONE: begin
        push      = accept && (response_time != 32'd0);
        cmd.op    = OP_LATENCY;
        cmd.value = timestamp - response_time;
        cmd.sel   = LAT_USB;
      end
      KIND_DEPTH: begin
        push      = accept;
        cmd.op    = OP_DEPTH;
        cmd.value = {24'd0, ring_depth};
      end
      KIND_PAGE_READ: begin
        push      = accept;
        cmd.value = timestamp - session_base;
        cmd.sel   = page_number[1:0];
        if (buffer_capacity < PAGE_BYTES_MIN || page_number > MAX_PAGE) begin
          cmd.op = OP_REJECT;
        end else begin
          cmd.op = OP_PAGE;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Track the event times that latencies are measured from
  always_ff @(posedge clk) begin
    if (rst) begin
      session_base   <= '0;
      send_done_time <= '0;
      ack_time       <= '0;
      response_time  <= '0;
    end else if (accept) begin
      case (kind)
        KIND_CLEAR: begin
          session_base   <= timestamp;
          send_done_time <= '0;
          ack_time       <= '0;
          response_time  <= '0;
        end
        KIND_USB_REQUEST: begin
          if (session_base == 32'd0) session_base <= timestamp;
        end
        KIND_RF_DONE:     send_done_time <= timestamp;
        KIND_ACK:         ack_time       <= timestamp;
        KIND_SWD_RESP:    response_time  <= timestamp;
        KIND_USB_IN_DONE: response_time  <= '0;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/dlpm_queue.sv
module dlpm_queue import dlpm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/dlpm_back.sv
module dlpm_back import dlpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] cycles_per_microsecond,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] data_word,
  output logic [3:0]  word_index,
  output logic        last_word,
  output logic [5:0]  returned_length
);

  back_state_t state;
  back_state_t state_next;

  logic [3:0]  idx;
  logic [1:0]  page;
  logic [31:0] elapsed;

  logic [31:0] usb_request_total;
  logic [31:0] command_class_counts [4];
  logic [31:0] transfer_item_total;
  logic [31:0] size_histogram [6];
  logic [31:0] radio_counters [3];
  logic [31:0] latency_sums [4];
  logic [31:0] latency_counts [4];
  logic [31:0] latency_maxima [4];
  logic [31:0] depth_sum;
  logic [31:0] depth_samples;
  logic [31:0] depth_max;

  logic        out_free;
  logic        is_read;
  logic        load;
  logic        load_reject;
  logic        update;
  logic [1:0]  cur_page;
  logic [3:0]  cur_idx;
  logic [31:0] cur_elapsed;
  logic [31:0] word_val;
  logic [32:0] lat_sum_add;
  logic [32:0] depth_sum_add;

  assign out_free = !out_valid || out_ready;
  assign is_read  = (head.op == OP_PAGE) || (head.op == OP_REJECT);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (head_valid && head.op == OP_PAGE && out_free) state_next = ST_PAGE;
      end
      ST_PAGE: begin
        if (out_free && idx == LAST_WORD_INDEX) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Pop, load and update strobes
  always_comb begin
    pop         = 1'b0;
    load        = 1'b0;
    load_reject = 1'b0;
    update      = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (head_valid) begin
          if (is_read) begin
            pop         = out_free;
            load        = out_free;
            load_reject = out_free && (head.op == OP_REJECT);
          end else begin
            pop    = 1'b1;
            update = 1'b1;
          end
        end
      end
      ST_PAGE: begin
        load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Word source: head for the first word, latched page after that
  assign cur_page    = (state == ST_PAGE) ? page : head.sel;
  assign cur_idx     = (state == ST_PAGE) ? idx : 4'd0;
  assign cur_elapsed = (state == ST_PAGE) ? elapsed : head.value;

  // Select one statistics word of the page
  always_comb begin
    word_val = '0;
    case (cur_page)
      2'd0: begin
        case (cur_idx)
          4'd0:  word_val = STATS_VERSION;
          4'd1:  word_val = {16'd0, cycles_per_microsecond};
          4'd2:  word_val = cur_elapsed;
          4'd3:  word_val = usb_request_total;
          4'd4:  word_val = command_class_counts[0];
          4'd5:  word_val = command_class_counts[1];
          4'd6:  word_val = command_class_counts[2];
          4'd7:  word_val = command_class_counts[3];
          4'd8:  word_val = transfer_item_total;
          4'd9:  word_val = size_histogram[0];
          4'd10: word_val = size_histogram[1];
          4'd11: word_val = size_histogram[2];
          4'd12: word_val = size_histogram[3];
          4'd13: word_val = size_histogram[4];
          4'd14: word_val = size_histogram[5];
          default: word_val = '0;
        endcase
      end
      2'd1: begin
        case (cur_idx)
          4'd0:  word_val = radio_counters[0];
          4'd1:  word_val = radio_counters[1];
          4'd2:  word_val = radio_counters[2];
          4'd3:  word_val = latency_sums[LAT_ACK];
          4'd4:  word_val = latency_counts[LAT_ACK];
          4'd5:  word_val = latency_maxima[LAT_ACK];
          4'd6:  word_val = latency_sums[LAT_SWD];
          4'd7:  word_val = latency_counts[LAT_SWD];
          4'd8:  word_val = latency_maxima[LAT_SWD];
          4'd9:  word_val = latency_sums[LAT_USB];
          4'd10: word_val = latency_counts[LAT_USB];
          4'd11: word_val = latency_maxima[LAT_USB];
          default: word_val = '0;
        endcase
      end
      2'd2: begin
        case (cur_idx)
          4'd0: word_val = latency_sums[LAT_RX];
          4'd1: word_val = latency_counts[LAT_RX];
          4'd2: word_val = latency_maxima[LAT_RX];
          4'd3: word_val = depth_max;
          4'd4: word_val = depth_sum;
          4'd5: word_val = depth_samples;
          default: word_val = '0;
        endcase
      end
      default: word_val = '0;
    endcase
  end

  // State and page sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (load) idx <= (state == ST_PAGE) ? idx + 4'd1 : 4'd1;
    end
  end

  // Latch page and elapsed time when a read starts
  always_ff @(posedge clk) begin
    if (state == ST_RUN && load) begin
      page    <= head.sel;
      elapsed <= head.value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (load_reject) begin
        data_word       <= '0;
        word_index      <= '0;
        last_word       <= 1'b1;
        returned_length <= '0;
      end else begin
        data_word       <= word_val;
        word_index      <= cur_idx;
        last_word       <= (cur_idx == LAST_WORD_INDEX);
        returned_length <= PAGE_BYTES;
      end
    end
  end

  assign lat_sum_add   = {1'b0, latency_sums[head.sel]} + {1'b0, head.value};
  assign depth_sum_add = {1'b0, depth_sum} + {1'b0, head.value};

  // Apply one event to the statistics
  always_ff @(posedge clk) begin
    if (rst || (update && head.op == OP_CLEAR)) begin
      usb_request_total   <= '0;
      transfer_item_total <= '0;
      depth_sum           <= '0;
      depth_samples       <= '0;
      depth_max           <= '0;
      for (int i = 0; i < 4; i++) begin
        command_class_counts[i] <= '0;
        latency_sums[i]         <= '0;
        latency_counts[i]       <= '0;
        latency_maxima[i]       <= '0;
      end
      for (int i = 0; i < 6; i++) size_histogram[i] <= '0;
      for (int i = 0; i < 3; i++) radio_counters[i] <= '0;
    end else if (update) begin
      case (head.op)
        OP_USB: begin
          if (usb_request_total != MAX32) usb_request_total <= usb_request_total + 32'd1;
          if (head.flag) begin
            command_class_counts[head.sel] <= command_class_counts[head.sel] + 32'd1;
          end
          if (head.bin_valid) begin
            transfer_item_total     <= transfer_item_total + head.value;
            size_histogram[head.bin] <= size_histogram[head.bin] + 32'd1;
          end
        end
        OP_RF: begin
          radio_counters[0] <= radio_counters[0] + 32'd1;
          radio_counters[1] <= radio_counters[1] + head.value;
          if (head.flag) radio_counters[2] <= radio_counters[2] + 32'd1;
        end
        OP_LATENCY: begin
          latency_sums[head.sel] <= lat_sum_add[32] ? MAX32 : lat_sum_add[31:0];
          if (latency_counts[head.sel] != MAX32) begin
            latency_counts[head.sel] <= latency_counts[head.sel] + 32'd1;
          end
          if (head.value > latency_maxima[head.sel]) latency_maxima[head.sel] <= head.value;
        end
        OP_DEPTH: begin
          depth_sum <= depth_sum_add[32] ? MAX32 : depth_sum_add[31:0];
          if (depth_samples != MAX32) depth_samples <= depth_samples + 32'd1;
          if (head.value > depth_max) depth_max <= head.value;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: dv/tb_debug_link_perf_monitor_unit.sv
module tb_debug_link_perf_monitor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dlpm_pkg::*;

  localparam int          RESET_CYCLES    = 12;
  localparam int          DRAIN_CYCLES    = 20;
  localparam int          QUIET_LIMIT     = 4000;
  localparam int          LONG_HOLD       = 300;
  localparam int          PAGE_WORD_COUNT = 15;
  localparam logic [15:0] CFG_RESET       = 16'd64;
  localparam logic [3:0]  KIND_SPARE_LO   = 4'd10;
  localparam logic [3:0]  KIND_SPARE_HI   = 4'd15;

  // One timestamped event as it travels on the input stream
  typedef struct {
    logic [3:0]  kind;
    logic [31:0] ts;
    logic [7:0]  cmd;
    logic [7:0]  req_len;
    logic [7:0]  cnt_lo;
    logic [7:0]  cnt_hi;
    logic [7:0]  frame_len;
    logic        retx;
    logic [7:0]  depth;
    logic [7:0]  page;
    logic [7:0]  room;
  } link_ev_t;

  // One statistics word of a page read
  typedef struct {
    logic [31:0] data;
    logic [3:0]  idx;
    logic        last;
    logic [5:0]  len;
  } page_word_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tlast;

  debug_link_perf_monitor_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  link_ev_t   pending_events[$];
  page_word_t expected_words[$];
  link_ev_t   tx_cur;
  page_word_t want;
  int         n_errors = 0;
  int         n_queued = 0;
  int         quiet = 0;
  int         long_req = 0;
  int         long_seen = 0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         rx_draw = 0;
  int         long_wait = 0;
  bit         tx_idle = 1'b1;
  bit         rx_idle = 1'b1;
  logic [31:0] sim_ts = '0;

  // Monitor statistics as the block should hold them
  logic [15:0] ticks_per_us;
  logic [31:0] sess_base, usb_total, item_total;
  logic [31:0] class_count[4];
  logic [31:0] size_hist[6];
  logic [31:0] rf_frames, rf_bytes, rf_retx;
  logic [31:0] lat_sum[4];
  logic [31:0] lat_cnt[4];
  logic [31:0] lat_max[4];
  logic [31:0] depth_sum, depth_samples, depth_max;
  logic [31:0] send_done_ts, ack_ts, resp_ts;

  task report_mismatch(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
    $display("mismatch %s: expected %h, got %h", what, want_v, got_v);
    n_errors++;
  endtask

  task clear_counters();
    sess_base  = '0;
    usb_total  = '0;
    item_total = '0;
    foreach (class_count[i]) class_count[i] = '0;
    foreach (size_hist[i]) size_hist[i] = '0;
    rf_frames = '0;
    rf_bytes  = '0;
    rf_retx   = '0;
    foreach (lat_sum[i]) begin
      lat_sum[i] = '0;
      lat_cnt[i] = '0;
      lat_max[i] = '0;
    end
    depth_sum     = '0;
    depth_samples = '0;
    depth_max     = '0;
    send_done_ts  = '0;
    ack_ts        = '0;
    resp_ts       = '0;
  endtask

  // Saturating sum and count, plain maximum
  task add_latency(input logic [1:0] slot, input logic [31:0] lat_val);
    if ({1'b0, lat_sum[slot]} + {1'b0, lat_val} > {1'b0, MAX32}) lat_sum[slot] = MAX32;
    else lat_sum[slot] += lat_val;
    if (lat_cnt[slot] != MAX32) lat_cnt[slot]++;
    if (lat_val > lat_max[slot]) lat_max[slot] = lat_val;
  endtask

  // Update the statistics for one accepted event, queue any page words
  task automatic apply_event(input link_ev_t ev);
    logic [15:0] count;
    logic [31:0] w[PAGE_WORD_COUNT];
    page_word_t  pw;
    int          hb;
    int          i;
    case (ev.kind)
      KIND_CLEAR: begin
        clear_counters();
        sess_base = ev.ts;
      end
      KIND_USB_REQUEST: begin
        count = '0;
        if (sess_base == 0) sess_base = ev.ts;
        if (usb_total != MAX32) usb_total++;
        if (ev.cmd == CMD_TRANSFER && ev.req_len >= 3) begin
          class_count[CLASS_TRANSFER]++;
          count = {8'd0, ev.cnt_lo};
        end else if (ev.cmd == CMD_TRANSFER_BLOCK && ev.req_len >= 5) begin
          class_count[CLASS_BLOCK]++;
          count = {ev.cnt_hi, ev.cnt_lo};
        end else if (ev.cmd == CMD_QUEUE) begin
          class_count[CLASS_QUEUE]++;
        end else if (ev.cmd == CMD_EXECUTE) begin
          class_count[CLASS_EXECUTE]++;
        end
        if (count != 0) begin
          item_total += {16'd0, count};
          if (count == 1) hb = 0;
          else if (count == 2) hb = 1;
          else if (count <= 4) hb = 2;
          else if (count <= 8) hb = 3;
          else if (count <= 12) hb = 4;
          else hb = 5;
          size_hist[hb]++;
        end
      end
      KIND_RF_START: begin
        rf_frames++;
        rf_bytes += {24'd0, ev.frame_len};
        if (ev.retx) rf_retx++;
      end
      KIND_RF_DONE: send_done_ts = ev.ts;
      KIND_RX_RESTORED: add_latency(LAT_RX, ev.ts - send_done_ts);
      KIND_ACK: begin
        add_latency(LAT_ACK, ev.ts - send_done_ts);
        ack_ts = ev.ts;
      end
      KIND_SWD_RESP: begin
        add_latency(LAT_SWD, ev.ts - ack_ts);
        resp_ts = ev.ts;
      end
      KIND_USB_IN_DONE: begin
        // no sample unless a response is outstanding
        if (resp_ts != 0) begin
          add_latency(LAT_USB, ev.ts - resp_ts);
          resp_ts = '0;
        end
      end
      KIND_DEPTH: begin
        if ({1'b0, depth_sum} + {25'd0, ev.depth} > {1'b0, MAX32}) depth_sum = MAX32;
        else depth_sum += {24'd0, ev.depth};
        if (depth_samples != MAX32) depth_samples++;
        if (ev.depth > depth_max) depth_max = {24'd0, ev.depth};
      end
      KIND_PAGE_READ: begin
        if (ev.room < PAGE_BYTES_MIN || ev.page > MAX_PAGE) begin
          pw = '{32'd0, 4'd0, 1'b1, 6'd0};
          expected_words.push_back(pw);
        end else begin
          foreach (w[j]) w[j] = '0;
          if (ev.page == 0) begin
            w[0] = STATS_VERSION;
            w[1] = {16'd0, ticks_per_us};
            w[2] = ev.ts - sess_base;
            w[3] = usb_total;
            for (i = 0; i < 4; i++) w[4 + i] = class_count[i];
            w[8] = item_total;
            for (i = 0; i < 6; i++) w[9 + i] = size_hist[i];
          end else if (ev.page == 1) begin
            w[0] = rf_frames;
            w[1] = rf_bytes;
            w[2] = rf_retx;
            for (i = 0; i < 3; i++) begin
              w[3 + 3 * i] = lat_sum[i];
              w[4 + 3 * i] = lat_cnt[i];
              w[5 + 3 * i] = lat_max[i];
            end
          end else begin
            w[0] = lat_sum[LAT_RX];
            w[1] = lat_cnt[LAT_RX];
            w[2] = lat_max[LAT_RX];
            w[3] = depth_max;
            w[4] = depth_sum;
            w[5] = depth_samples;
          end
          for (i = 0; i < PAGE_WORD_COUNT; i++) begin
            pw.data = w[i];
            pw.idx  = 4'(i);
            pw.last = (4'(i) == LAST_WORD_INDEX);
            pw.len  = PAGE_BYTES;
            expected_words.push_back(pw);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Random filler in every field but the kind and the timestamp
  function automatic link_ev_t make_ev(input logic [3:0] k, input logic [31:0] ts);
    link_ev_t ev;
    ev.kind      = k;
    ev.ts        = ts;
    ev.cmd       = 8'($urandom);
    ev.req_len   = 8'($urandom);
    ev.cnt_lo    = 8'($urandom);
    ev.cnt_hi    = 8'($urandom);
    ev.frame_len = 8'($urandom);
    ev.retx      = 1'($urandom);
    ev.depth     = 8'($urandom);
    ev.page      = 8'($urandom);
    ev.room      = 8'($urandom);
    return ev;
  endfunction

  function automatic link_ev_t make_usb(input logic [31:0] ts, input logic [7:0] cmd,
                                        input logic [7:0] len, input logic [7:0] lo,
                                        input logic [7:0] hi);
    link_ev_t ev;
    ev         = make_ev(KIND_USB_REQUEST, ts);
    ev.cmd     = cmd;
    ev.req_len = len;
    ev.cnt_lo  = lo;
    ev.cnt_hi  = hi;
    return ev;
  endfunction

  function automatic link_ev_t make_page(input logic [31:0] ts, input logic [7:0] page,
                                         input logic [7:0] room);
    link_ev_t ev;
    ev      = make_ev(KIND_PAGE_READ, ts);
    ev.page = page;
    ev.room = room;
    return ev;
  endfunction

  // Mostly small steps forward, now and then a jump anywhere
  function automatic logic [31:0] next_ts();
    if ($urandom_range(0, 19) == 0) sim_ts = $urandom;
    else sim_ts += $urandom_range(1, 4000);
    return sim_ts;
  endfunction

  task push_ev(input link_ev_t ev);
    pending_events.push_back(ev);
    if (ev.kind <= KIND_PAGE_READ) n_queued++;
  endtask

  task wait_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_cfg(input logic [15:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    ticks_per_us = v;
    @(negedge clk);
  endtask

  // Mostly full request round trips with random content, plus page reads and noise
  task automatic gen_random(input int target);
    int          start_cnt;
    int          r;
    link_ev_t    ev;
    logic [7:0]  c;
    logic [7:0]  pg;
    logic [7:0]  rm;
    start_cnt = n_queued;
    while (n_queued - start_cnt < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        case ($urandom_range(0, 4))
          0: c = CMD_TRANSFER;
          1: c = CMD_TRANSFER_BLOCK;
          2: c = CMD_QUEUE;
          3: c = CMD_EXECUTE;
          default: c = 8'($urandom);
        endcase
        push_ev(make_usb(next_ts(), c,
                         $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)),
                         $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 16)),
                         $urandom_range(0, 1) == 0 ? 8'd0 : 8'($urandom)));
        if ($urandom_range(0, 99) < 85) begin
          ev = make_ev(KIND_RF_START, next_ts());
          ev.retx = ($urandom_range(0, 3) == 0);
          push_ev(ev);
        end
        if ($urandom_range(0, 99) < 85) push_ev(make_ev(KIND_RF_DONE, next_ts()));
        if ($urandom_range(0, 99) < 85) push_ev(make_ev(KIND_ACK, next_ts()));
        if ($urandom_range(0, 99) < 85) push_ev(make_ev(KIND_SWD_RESP, next_ts()));
        if ($urandom_range(0, 99) < 85) push_ev(make_ev(KIND_USB_IN_DONE, next_ts()));
        if ($urandom_range(0, 99) < 50) push_ev(make_ev(KIND_RX_RESTORED, next_ts()));
        if ($urandom_range(0, 99) < 50) push_ev(make_ev(KIND_DEPTH, next_ts()));
      end else if (r < 75) begin
        pg = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        rm = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 59))
                                          : 8'($urandom_range(60, 255));
        push_ev(make_page(next_ts(), pg, rm));
      end else if (r < 78) begin
        push_ev(make_ev(KIND_CLEAR, next_ts()));
      end else begin
        push_ev(make_ev(4'($urandom_range(0, KIND_SPARE_HI)), $urandom));
      end
    end
  endtask

  // Drive events from the pending queue, predict each word on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_event(tx_cur);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          tx_cur = pending_events.pop_front();
          s_axis_tdata <= {7'd0, tx_cur.room, tx_cur.page, tx_cur.depth, tx_cur.retx,
                           tx_cur.frame_len, tx_cur.cnt_hi, tx_cur.cnt_lo,
                           tx_cur.req_len, tx_cur.cmd, tx_cur.ts};
          s_axis_tuser  <= tx_cur.kind;
          s_axis_tvalid <= 1'b1;
          tx_gap        <= tx_idle ? $urandom_range(0, 7) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check page words and throttle the result side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
      long_wait     <= 0;
      long_seen     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", '0, m_axis_tdata[31:0]);
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[31:0] !== want.data)
            report_mismatch("data_word", want.data, m_axis_tdata[31:0]);
          if (m_axis_tdata[35:32] !== want.idx)
            report_mismatch("word_index", {28'd0, want.idx}, {28'd0, m_axis_tdata[35:32]});
          if (m_axis_tdata[41:36] !== want.len)
            report_mismatch("returned_length", {26'd0, want.len}, {26'd0, m_axis_tdata[41:36]});
          if (m_axis_tlast !== want.last)
            report_mismatch("last_word", {31'd0, want.last}, {31'd0, m_axis_tlast});
        end
      end
      if (long_seen != long_req) begin
        long_seen     <= long_req;
        long_wait     <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (long_wait != 0) begin
        long_wait     <= long_wait - 1;
        m_axis_tready <= (long_wait == 1);
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_draw = rx_idle ? $urandom_range(0, 7) : 0;
        rx_gap        <= rx_draw;
        m_axis_tready <= (rx_draw == 0);
      end else if (rx_gap != 0) begin
        rx_gap        <= rx_gap - 1;
        m_axis_tready <= (rx_gap == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Give up when neither side moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    link_ev_t ev;
    int       ph;
    logic [15:0] cfg_val;
    ticks_per_us = CFG_RESET;
    clear_counters();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset contents, each request class, latencies, pages, rejects
    push_ev(make_page(32'd50, 8'd0, PAGE_BYTES_MIN));
    push_ev(make_ev(KIND_USB_IN_DONE, 32'd100));
    push_ev(make_usb(32'd200, CMD_TRANSFER, 8'd3, 8'd1, 8'd0));
    push_ev(make_usb(32'd300, CMD_TRANSFER_BLOCK, 8'd5, 8'hFF, 8'hFF));
    push_ev(make_usb(32'd310, CMD_TRANSFER, 8'd2, 8'd7, 8'd0));
    push_ev(make_usb(32'd320, CMD_QUEUE, 8'd0, 8'd0, 8'd0));
    push_ev(make_usb(32'd330, CMD_EXECUTE, 8'hFF, 8'd0, 8'd0));
    push_ev(make_usb(32'd340, CMD_TRANSFER_BLOCK, 8'd4, 8'd2, 8'd0));
    push_ev(make_usb(32'd350, CMD_TRANSFER_BLOCK, 8'd5, 8'd0, 8'd0));
    ev = make_ev(KIND_RF_START, 32'd900);
    ev.frame_len = 8'hFF;
    ev.retx      = 1'b1;
    push_ev(ev);
    push_ev(make_ev(KIND_RF_DONE, 32'd1000));
    push_ev(make_ev(KIND_ACK, 32'd1500));
    push_ev(make_ev(KIND_SWD_RESP, 32'd1600));
    push_ev(make_ev(KIND_USB_IN_DONE, 32'd1700));
    push_ev(make_ev(KIND_RX_RESTORED, 32'd10));
    ev = make_ev(KIND_DEPTH, 32'd1800);
    ev.depth = 8'hFF;
    push_ev(ev);
    ev = make_ev(KIND_DEPTH, 32'd1900);
    ev.depth = 8'd0;
    push_ev(ev);
    push_ev(make_ev(KIND_SPARE_LO, 32'hFFFF_FFFF));
    push_ev(make_ev(KIND_SPARE_HI, 32'd0));
    push_ev(make_page(32'd2000, 8'd1, 8'hFF));
    push_ev(make_page(32'd2100, MAX_PAGE, PAGE_BYTES_MIN));
    push_ev(make_page(32'd2200, MAX_PAGE + 8'd1, 8'hFF));
    push_ev(make_page(32'd2300, 8'd0, PAGE_BYTES_MIN - 8'd1));
    push_ev(make_ev(KIND_CLEAR, 32'hFFFF_FFF0));
    push_ev(make_ev(KIND_SWD_RESP, 32'd0));
    push_ev(make_ev(KIND_USB_IN_DONE, 32'd5));
    push_ev(make_page(32'h20, 8'd0, PAGE_BYTES_MIN));

    // Hold the result side off while events keep coming, so the input stalls
    write_cfg(16'd1);
    tx_idle = 1'b0;
    long_req++;
    push_ev(make_page(next_ts(), 8'd0, 8'hFF));
    gen_random(24);

    // Random phases, each under its own register setting and idling mix
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: cfg_val = 16'hFFFF;
        2: cfg_val = CFG_RESET;
        default: cfg_val = 16'($urandom_range(1, 65535));
      endcase
      write_cfg(cfg_val);
      tx_idle = (ph % 2 == 0);
      rx_idle = (ph != 3);
      gen_random(55);
    end

    wait_idle();
    if (n_errors == 0 && expected_words.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
